@@ hdl/adsc_pkg.sv @@
`default_nettype none

package adsc_pkg;

  // Item function codes
  typedef enum logic [2:0] {
    FUNC_WR_STATUS = 3'd0,
    FUNC_WR_CH0    = 3'd1,
    FUNC_WR_CH1    = 3'd2,
    FUNC_RESTART   = 3'd3,
    FUNC_READ      = 3'd4
  } func_t;

  // Operations handed from the front to the back
  typedef enum logic [2:0] {
    OP_WR_STATUS,
    OP_WR_CH0,
    OP_WR_CH1,
    OP_RESTART,
    OP_READ
  } op_kind_t;

  localparam int WORD_W    = 24;
  localparam int CRC_W     = 16;
  localparam int NUM_WORDS = 3;
  localparam int MSG_W     = NUM_WORDS * WORD_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [1:0]        word_sel_t;

  localparam word_sel_t SEL_STATUS = 2'd0;
  localparam word_sel_t SEL_CH0    = 2'd1;
  localparam word_sel_t SEL_CH1    = 2'd2;

  // One queued operation with the CRC share of the written word
  typedef struct packed {
    op_kind_t kind;
    word_t    value;
    crc_t     crc_part;
  } op_t;

  // Frame layout
  localparam logic [3:0] IDX_PAD     = 4'd9;
  localparam logic [3:0] IDX_CRC_HI  = 4'd10;
  localparam logic [3:0] IDX_CRC_LO  = 4'd11;
  localparam logic [3:0] FRAME_BYTES = 4'd12;

  localparam logic [7:0] PAD_BYTE  = 8'h00;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  localparam crc_t CRC_POLY = 16'h1021;
  localparam crc_t CRC_INIT = 16'hFFFF;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0][CRC_W-1:0] crc_cols_t;

  // One CRC-16-CCITT step, message bit first in
  function automatic crc_t crc_bit_step(crc_t c, logic b);
    logic fb;
    fb = c[CRC_W-1] ^ b;
    return {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
  endfunction

  // Serial CRC over a whole frame body, used only at elaboration
  function automatic crc_t crc_of_msg(logic [MSG_W-1:0] msg, crc_t init);
    crc_t c;
    c = init;
    for (int k = MSG_W - 1; k >= 0; k--) begin
      c = crc_bit_step(c, msg[k]);
    end
    return c;
  endfunction

  // CRC columns: share of each word bit with zero preset
  function automatic crc_cols_t build_cols();
    crc_cols_t        cols;
    logic [MSG_W-1:0] msg;
    for (int w = 0; w < NUM_WORDS; w++) begin
      for (int i = 0; i < WORD_W; i++) begin
        msg = '0;
        msg[(NUM_WORDS - 1 - w) * WORD_W + i] = 1'b1;
        cols[w][i] = crc_of_msg(msg, '0);
      end
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = build_cols();
  // Preset term: CRC of an all-zero body from the 0xFFFF preset
  localparam crc_t CRC_BASE = crc_of_msg('0, CRC_INIT);

  // Linear CRC share of one word: an XOR network per CRC bit
  function automatic crc_t crc_part(word_sel_t sel, word_t value);
    crc_t  p;
    word_t m;
    p = '0;
    for (int j = 0; j < CRC_W; j++) begin
      for (int i = 0; i < WORD_W; i++) begin
        m[i] = CRC_COLS[sel][i][j];
      end
      p[j] = ^(value & m);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

@@ hdl/adsc_in_if.sv @@
`default_nettype none

// Input item channel
interface adsc_in_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           func;
  adsc_pkg::word_t      value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/adsc_out_if.sv @@
`default_nettype none

// Result item channel
interface adsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] miso_byte;
  logic       past_end;

  modport source (output valid, output miso_byte, output past_end, input ready);
  modport sink   (input valid, input miso_byte, input past_end, output ready);
endinterface

`default_nettype wire

@@ hdl/adsc_front.sv @@
`default_nettype none

module adsc_front (
  adsc_in_if.sink          in_ch,
  input  wire logic        q_full,
  output adsc_pkg::op_t    q_op,
  output logic             q_push
);

  adsc_pkg::word_sel_t sel;
  logic                known;

  // Decode the function code; unused codes are dropped here
  always_comb begin
    q_op.kind  = adsc_pkg::OP_READ;
    q_op.value = in_ch.value;
    sel        = adsc_pkg::SEL_STATUS;
    known      = 1'b1;
    unique case (in_ch.func)
      adsc_pkg::FUNC_WR_STATUS: begin
        q_op.kind = adsc_pkg::OP_WR_STATUS;
        sel       = adsc_pkg::SEL_STATUS;
      end
      adsc_pkg::FUNC_WR_CH0: begin
        q_op.kind = adsc_pkg::OP_WR_CH0;
        sel       = adsc_pkg::SEL_CH0;
      end
      adsc_pkg::FUNC_WR_CH1: begin
        q_op.kind = adsc_pkg::OP_WR_CH1;
        sel       = adsc_pkg::SEL_CH1;
      end
      adsc_pkg::FUNC_RESTART: q_op.kind = adsc_pkg::OP_RESTART;
      adsc_pkg::FUNC_READ:    q_op.kind = adsc_pkg::OP_READ;
      default:                known = 1'b0;
    endcase
    // CRC share of a written word travels with the item
    q_op.crc_part = adsc_pkg::crc_part(sel, in_ch.value);
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full && known;

endmodule

`default_nettype wire

@@ hdl/adsc_queue.sv @@
`default_nettype none

module adsc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  adsc_pkg::op_t      push_op,
  input  wire logic          pop,
  output adsc_pkg::op_t      pop_op,
  output logic               nonempty,
  output logic               full
);

  adsc_pkg::op_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  assign pop_op   = mem_r[rd_ptr_r];
  assign nonempty = (count_r != 2'd0);
  assign full     = (count_r == 2'd2);

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != 2'd2)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count overflow");

endmodule

`default_nettype wire

@@ hdl/adsc_back.sv @@
`default_nettype none

module adsc_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  adsc_pkg::op_t    q_op,
  output logic             q_pop,
  adsc_out_if.source       out_ch
);

  adsc_pkg::word_t status_r, ch0_r, ch1_r;
  adsc_pkg::crc_t  crc_st_r, crc_c0_r, crc_c1_r;
  logic [3:0]      byte_index_r, byte_index_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r;
  logic            out_past_end_r;
  adsc_pkg::crc_t  crc;
  logic [7:0]      frame_byte;
  logic            is_read;
  logic            out_free;

  // Current frame CRC from the per-word shares
  assign crc = adsc_pkg::CRC_BASE ^ crc_st_r ^ crc_c0_r ^ crc_c1_r;

  // Frame byte at the current position
  always_comb begin
    unique case (byte_index_r)
      4'd0:                 frame_byte = status_r[23:16];
      4'd1:                 frame_byte = status_r[15:8];
      4'd2:                 frame_byte = status_r[7:0];
      4'd3:                 frame_byte = ch0_r[23:16];
      4'd4:                 frame_byte = ch0_r[15:8];
      4'd5:                 frame_byte = ch0_r[7:0];
      4'd6:                 frame_byte = ch1_r[23:16];
      4'd7:                 frame_byte = ch1_r[15:8];
      4'd8:                 frame_byte = ch1_r[7:0];
      adsc_pkg::IDX_PAD:    frame_byte = adsc_pkg::PAD_BYTE;
      adsc_pkg::IDX_CRC_HI: frame_byte = crc[15:8];
      adsc_pkg::IDX_CRC_LO: frame_byte = crc[7:0];
      default:              frame_byte = adsc_pkg::IDLE_BYTE;
    endcase
  end

  // Writes never wait; a read waits for a free output register
  assign is_read  = (q_op.kind == adsc_pkg::OP_READ);
  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = q_valid && (!is_read || out_free);

  // Index and output handshake next state
  always_comb begin
    byte_index_nxt = byte_index_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    if (q_pop) begin
      priority case (q_op.kind)
        adsc_pkg::OP_RESTART: byte_index_nxt = '0;
        adsc_pkg::OP_READ: begin
          out_valid_nxt = 1'b1;
          if (byte_index_r < adsc_pkg::FRAME_BYTES) begin
            byte_index_nxt = byte_index_r + 4'd1;
          end
        end
        default: byte_index_nxt = byte_index_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r     <= '0;
      ch0_r        <= '0;
      ch1_r        <= '0;
      crc_st_r     <= '0;
      crc_c0_r     <= '0;
      crc_c1_r     <= '0;
      byte_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_index_r <= byte_index_nxt;
      out_valid_r  <= out_valid_nxt;
      if (q_pop && q_op.kind == adsc_pkg::OP_WR_STATUS) begin
        status_r <= q_op.value;
        crc_st_r <= q_op.crc_part;
      end
      if (q_pop && q_op.kind == adsc_pkg::OP_WR_CH0) begin
        ch0_r    <= q_op.value;
        crc_c0_r <= q_op.crc_part;
      end
      if (q_pop && q_op.kind == adsc_pkg::OP_WR_CH1) begin
        ch1_r    <= q_op.value;
        crc_c1_r <= q_op.crc_part;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (q_pop && is_read) begin
      out_byte_r     <= frame_byte;
      out_past_end_r <= (byte_index_r >= adsc_pkg::FRAME_BYTES);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.miso_byte = out_byte_r;
  assign out_ch.past_end  = out_past_end_r;

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= adsc_pkg::FRAME_BYTES)
    else $error("byte index beyond frame");

  a_past_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_past_end_r |-> out_byte_r == adsc_pkg::IDLE_BYTE)
    else $error("past-end result without idle byte");

  a_read_advances: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && is_read && byte_index_r < adsc_pkg::FRAME_BYTES
    |=> byte_index_r == 4'($past(byte_index_r) + 4'd1))
    else $error("read did not advance index");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_op.kind == adsc_pkg::OP_RESTART |=> byte_index_r == 4'd0)
    else $error("restart did not clear index");

endmodule

`default_nettype wire

@@ hdl/adc_spi_frame_readout_crc_core.sv @@
`default_nettype none

// Channel  Dir  Payload                         Result
// in_ch    in   func[2:0], value[23:0]          writes, restart, byte read
// out_ch   out  miso_byte[7:0], past_end        one item per read
//
// One item per cycle sustained while the output does not stall; the front
// decodes and queues, the back executes. A read's byte passes through the
// queue and then the output register. The CRC is kept as per-word shares.
// Reset clears the words, the byte index, the queue and the output valid.
// A stalled output holds back a read at the queue head and everything queued
// behind it; in_ch.ready falls only when the two-entry queue is full.

module adc_spi_frame_readout_crc_core (
  input  wire logic    clk,
  input  wire logic    rst_n,
  adsc_in_if.sink      in_ch,
  adsc_out_if.source   out_ch
);

  adsc_pkg::op_t push_op;
  adsc_pkg::op_t pop_op;
  logic          push;
  logic          pop;
  logic          nonempty;
  logic          full;

  adsc_front u_front (
    .in_ch  (in_ch),
    .q_full (full),
    .q_op   (push_op),
    .q_push (push)
  );

  adsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_op  (push_op),
    .pop      (pop),
    .pop_op   (pop_op),
    .nonempty (nonempty),
    .full     (full)
  );

  adsc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (nonempty),
    .q_op    (pop_op),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ sim/adc_spi_frame_readout_crc_core_tb.sv @@
`timescale 1ns / 1ps

module adc_spi_frame_readout_crc_core_tb;

  // Codes 5..7 are not decoded by the block
  localparam logic [2:0] FUNC_UNUSED_MIN = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_MID = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_MAX = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Byte as it should come out of the result channel
  typedef struct {
    logic [7:0] miso_byte;
    logic       past_end;
  } spi_byte_t;

  // Tracks the register file and read position, predicts each MISO byte
  class frame_byte_tracker;
    adsc_pkg::word_t status_word;
    adsc_pkg::word_t ch0_sample;
    adsc_pkg::word_t ch1_sample;
    logic [3:0]      read_pos;
    spi_byte_t       pending_bytes[$];
    int unsigned     mismatches;
    int unsigned     bytes_checked;
    int unsigned     end_reads;
    int unsigned     writes;
    int unsigned     restarts;
    int unsigned     ignored;

    function new();
      status_word   = '0;
      ch0_sample    = '0;
      ch1_sample    = '0;
      read_pos      = '0;
      mismatches    = 0;
      bytes_checked = 0;
      end_reads     = 0;
      writes        = 0;
      restarts      = 0;
      ignored       = 0;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // CRC-16-CCITT, MSB first, over status/ch0/ch1 bytes
    function adsc_pkg::crc_t body_crc();
      logic [71:0]    body;
      adsc_pkg::crc_t crc;
      body = {status_word, ch0_sample, ch1_sample};
      crc  = adsc_pkg::CRC_INIT;
      for (int k = 0; k < 9; k++) begin
        crc ^= {body[71 - 8 * k -: 8], 8'h00};
        for (int b = 0; b < 8; b++) begin
          if (crc[15]) crc = {crc[14:0], 1'b0} ^ adsc_pkg::CRC_POLY;
          else crc = {crc[14:0], 1'b0};
        end
      end
      return crc;
    endfunction

    function logic [7:0] byte_at(logic [3:0] pos);
      logic [71:0]    body;
      adsc_pkg::crc_t crc;
      body = {status_word, ch0_sample, ch1_sample};
      crc  = body_crc();
      if (pos < adsc_pkg::IDX_PAD) return body[71 - 8 * pos -: 8];
      if (pos == adsc_pkg::IDX_PAD) return adsc_pkg::PAD_BYTE;
      if (pos == adsc_pkg::IDX_CRC_HI) return crc[15:8];
      return crc[7:0];
    endfunction

    // Called for every accepted input item
    function void take_item(logic [2:0] f, adsc_pkg::word_t v);
      spi_byte_t nb;
      case (f)
        adsc_pkg::FUNC_WR_STATUS: begin status_word = v; writes++; end
        adsc_pkg::FUNC_WR_CH0:    begin ch0_sample = v;  writes++; end
        adsc_pkg::FUNC_WR_CH1:    begin ch1_sample = v;  writes++; end
        adsc_pkg::FUNC_RESTART:   begin read_pos = '0;   restarts++; end
        adsc_pkg::FUNC_READ: begin
          if (read_pos < adsc_pkg::FRAME_BYTES) begin
            nb.miso_byte = byte_at(read_pos);
            nb.past_end  = 1'b0;
            read_pos++;
          end else begin
            nb.miso_byte = adsc_pkg::IDLE_BYTE;
            nb.past_end  = 1'b1;
          end
          pending_bytes.push_back(nb);
        end
        default: ignored++;
      endcase
    endfunction

    // Called for every accepted result item
    task match_byte(logic [7:0] got_byte, logic got_end);
      spi_byte_t exp_b;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h end=%0b", got_byte, got_end));
      end else begin
        exp_b = pending_bytes.pop_front();
        bytes_checked++;
        if (exp_b.past_end) end_reads++;
        if (got_byte !== exp_b.miso_byte)
          report_mismatch($sformatf("miso_byte %02h, expected %02h",
                                    got_byte, exp_b.miso_byte));
        if (got_end !== exp_b.past_end)
          report_mismatch($sformatf("past_end %0b, expected %0b",
                                    got_end, exp_b.past_end));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  adsc_in_if  in_ch();
  adsc_out_if out_ch();

  adc_spi_frame_readout_crc_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_byte_tracker tracker = new();

  int unsigned items_done;
  int unsigned burst_left;
  int unsigned ready_span;
  logic [1:0]  ready_style;

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.func   = adsc_pkg::FUNC_WR_STATUS;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    items_done   = 0;
    burst_left   = 20;
    ready_span   = 0;
    ready_style  = 2'd0;
  end

  always #2 clk = ~clk;

  // Run limit
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // Receiver: stall style changes every stretch of cycles
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.match_byte(out_ch.miso_byte, out_ch.past_end);
    if (ready_span == 0) begin
      ready_span  = $urandom_range(16, 200);
      ready_style = 2'($urandom_range(0, 3));
    end
    ready_span--;
    case (ready_style)
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ch.ready <= ($urandom_range(0, 7) != 0);
      default: out_ch.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Drive one item, wait for acceptance, then maybe idle between bursts
  task automatic send_item(input logic [2:0] f, input adsc_pkg::word_t v);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_item(f, v);
    if (f <= adsc_pkg::FUNC_READ) items_done++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = $urandom_range(1, 8);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic adsc_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h800000;
      3:       return 24'h7FFFFF;
      default: return adsc_pkg::word_t'($urandom());
    endcase
  endfunction

  task automatic write_random_word();
    send_item(3'($urandom_range(adsc_pkg::FUNC_WR_STATUS, adsc_pkg::FUNC_WR_CH1)),
              pick_word());
  endtask

  task automatic read_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(adsc_pkg::FUNC_READ, pick_word());
  endtask

  // One random sequence: mostly whole frames, some broken ones and noise
  task automatic frame_sequence();
    int unsigned kind;
    int unsigned n;
    int unsigned cut;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      n = $urandom_range(0, 3);
      for (int unsigned i = 0; i < n; i++) write_random_word();
      send_item(adsc_pkg::FUNC_RESTART, pick_word());
      n = adsc_pkg::FRAME_BYTES + $urandom_range(0, 2);
      // sometimes a word changes while the frame is being read
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n + 1;
      for (int unsigned i = 0; i < n; i++) begin
        if (i == cut) write_random_word();
        send_item(adsc_pkg::FUNC_READ, pick_word());
      end
    end else if (kind == 7) begin
      send_item(adsc_pkg::FUNC_RESTART, pick_word());
      read_bytes($urandom_range(1, 11));
    end else if (kind == 8) begin
      n = $urandom_range(1, 4);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) == 0)
          send_item(3'($urandom_range(FUNC_UNUSED_MIN, FUNC_UNUSED_MAX)), pick_word());
        else
          send_item(3'($urandom_range(adsc_pkg::FUNC_WR_STATUS, adsc_pkg::FUNC_READ)),
                    pick_word());
      end
    end else begin
      read_bytes($urandom_range(1, 14));
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned settle;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads of the reset-value frame, unused codes, extreme words,
    // a write in mid-frame, and reads beyond the frame end
    read_bytes(2);
    send_item(FUNC_UNUSED_MIN, 24'hFFFFFF);
    send_item(FUNC_UNUSED_MID, 24'hFFFFFF);
    send_item(FUNC_UNUSED_MAX, 24'hFFFFFF);
    send_item(adsc_pkg::FUNC_WR_STATUS, 24'hFFFFFF);
    send_item(adsc_pkg::FUNC_WR_CH0, 24'h800000);
    send_item(adsc_pkg::FUNC_WR_CH1, 24'h7FFFFF);
    send_item(adsc_pkg::FUNC_RESTART, 24'h000000);
    read_bytes(5);
    send_item(adsc_pkg::FUNC_WR_CH1, 24'h000001);
    read_bytes(9);

    // Random sequences
    target = items_done + RANDOM_ITEMS;
    while (items_done < target) frame_sequence();
    in_ch.valid <= 1'b0;

    // Drain, then let trailing output activity show up
    while (tracker.pending_bytes.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < SETTLE_CYCLES) begin
      @(posedge clk);
      settle++;
    end

    $display("covered %0d items: %0d writes, %0d restarts, %0d ignored codes",
             items_done, tracker.writes, tracker.restarts, tracker.ignored);
    $display("checked %0d MISO bytes, %0d of them past the frame end, %0d mismatches",
             tracker.bytes_checked, tracker.end_reads, tracker.mismatches);
    if (tracker.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
